// ----- hw/rtl/zoned_slot_allocator_assert.svh -----
// ----------------------------------------------------------------------------
// zoned slot allocator assertion macros
// ----------------------------------------------------------------------------
`ifndef ZONED_SLOT_ALLOCATOR_ASSERT_SVH
`define ZONED_SLOT_ALLOCATOR_ASSERT_SVH

// property must hold at every clock edge outside reset
`define ZSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ZSA_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/zsa_pkg.sv -----
// ----------------------------------------------------------------------------
// zsa_pkg
// shared constants and types of the zoned slot allocator
// ----------------------------------------------------------------------------
package zsa_pkg;

  localparam int SLOTS_PER_ZONE = 64;
  localparam int MAX_ZONES      = 8;
  localparam int SIZE_LIMIT     = 128;

  localparam int SLOT_W  = $clog2(SLOTS_PER_ZONE);
  localparam int ZONE_W  = $clog2(MAX_ZONES);
  localparam int SIZE_W  = $clog2(SIZE_LIMIT + 1);
  localparam int REQ_W   = 16;
  localparam int CNT_W   = 7;
  localparam int BYTES_W = 14;
  localparam int ENA_W   = 4;
  localparam int STAT_W  = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_LARGE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADFREE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_READ   = 3'b010,
    S_UPDATE = 3'b100
  } state_e;

endpackage

// ----- hw/rtl/zsa_ram.sv -----
// ----------------------------------------------------------------------------
// zsa_ram
// single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module zsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- hw/rtl/zoned_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// zoned_slot_allocator
// first-fit slot allocator over zones, busy map and slot sizes held in ram
// ----------------------------------------------------------------------------
// the result strobe follows an accepted start through the read and update states
// a new word is taken only back in idle, after the busy-map ram read and write-back
// the receiver cannot stall; done_o is high for exactly one cycle per word
// reset: every slot free, zone counters zero, one zone active
// the slot size ram is not cleared; it is only read for slots in use
// ----------------------------------------------------------------------------
`include "zoned_slot_allocator_assert.svh"

module zoned_slot_allocator
  import zsa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [REQ_W-1:0]   request_size_i,
  input  logic [ZONE_W-1:0]  free_zone_i,
  input  logic [SLOT_W-1:0]  free_slot_i,
  output logic               done_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [ZONE_W-1:0]  granted_zone_o,
  output logic [SLOT_W-1:0]  granted_slot_o,
  output logic [CNT_W-1:0]   zone_used_count_o,
  output logic [BYTES_W-1:0] zone_byte_total_o,
  output logic [ENA_W-1:0]   active_zone_count_o
);

  state_e state_q, state_d;

  logic               func_q;
  logic [REQ_W-1:0]   size_q;
  logic [ZONE_W-1:0]  fz_q;
  logic [SLOT_W-1:0]  fs_q;
  logic [ZONE_W-1:0]  zone_q, zone_d;
  status_e            st_q, st_d;
  logic [ENA_W-1:0]   ena_q, ena_d;
  logic [CNT_W-1:0]   cnt_q [MAX_ZONES];
  logic [BYTES_W-1:0] bytes_q [MAX_ZONES];
  logic [MAX_ZONES-1:0] row_vld_q;
  logic               rd_vld_q;

  logic               done_q;
  status_e            res_st_q, res_st_d;
  logic [ZONE_W-1:0]  res_zone_q, res_zone_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic [CNT_W-1:0]   res_cnt_q, res_cnt_d;
  logic [BYTES_W-1:0] res_bytes_q, res_bytes_d;

  logic accept;
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // ram ports
  logic                         map_we;
  logic [ZONE_W-1:0]            map_addr;
  logic [SLOTS_PER_ZONE-1:0]    map_wdata, map_rdata;
  logic                         sz_we;
  logic [ZONE_W+SLOT_W-1:0]     sz_addr;
  logic [SIZE_W-1:0]            sz_rdata;

  zsa_ram #(
    .Width (SLOTS_PER_ZONE),
    .Depth (MAX_ZONES)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  zsa_ram #(
    .Width (SIZE_W),
    .Depth (MAX_ZONES * SLOTS_PER_ZONE)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (sz_we),
    .addr_i  (sz_addr),
    .wdata_i (size_q[SIZE_W-1:0]),
    .rdata_o (sz_rdata)
  );

  // first active zone that still has a free slot
  logic              zfound;
  logic [ZONE_W-1:0] zfirst;
  always_comb begin
    zfound = 1'b0;
    zfirst = '0;
    for (int z = MAX_ZONES - 1; z >= 0; z--) begin
      if ((ENA_W'(z) < ena_q) && (cnt_q[z] != CNT_W'(SLOTS_PER_ZONE))) begin
        zfound = 1'b1;
        zfirst = ZONE_W'(z);
      end
    end
  end

  logic [ENA_W:0]   ena_dbl;
  logic [ENA_W-1:0] ena_grow;
  assign ena_dbl  = {ena_q, 1'b0};
  assign ena_grow = (ena_dbl > (ENA_W + 1)'(MAX_ZONES)) ? ENA_W'(MAX_ZONES)
                                                        : ena_dbl[ENA_W-1:0];

  // row seen through the per-row valid bit, then lowest free slot
  logic [SLOTS_PER_ZONE-1:0] row;
  logic [SLOT_W-1:0]         pe_slot;
  assign row = rd_vld_q ? map_rdata : '0;
  always_comb begin
    pe_slot = '0;
    for (int s = SLOTS_PER_ZONE - 1; s >= 0; s--) begin
      if (!row[s]) begin
        pe_slot = SLOT_W'(s);
      end
    end
  end

  logic slot_busy;
  assign slot_busy = row[fs_q];

  logic cnt_we;

  always_comb begin
    state_d     = state_q;
    zone_d      = zone_q;
    st_d        = st_q;
    ena_d       = ena_q;
    map_we      = 1'b0;
    map_addr    = zone_q;
    map_wdata   = row;
    sz_we       = 1'b0;
    sz_addr     = {fz_q, fs_q};
    cnt_we      = 1'b0;
    res_st_d    = st_q;
    res_zone_d  = '0;
    res_slot_d  = '0;
    res_cnt_d   = '0;
    res_bytes_d = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPDATE;
        if (func_q == FUNC_ALLOC) begin
          if (size_q == '0) begin
            st_d = ST_ZERO;
          end else if (size_q > REQ_W'(SIZE_LIMIT)) begin
            st_d = ST_LARGE;
          end else if (zfound) begin
            st_d   = ST_OK;
            zone_d = zfirst;
          end else if (ena_q >= ENA_W'(MAX_ZONES)) begin
            st_d = ST_FULL;
          end else begin
            // grow: the first new zone is empty
            st_d   = ST_OK;
            zone_d = ena_q[ZONE_W-1:0];
            ena_d  = ena_grow;
          end
        end else begin
          if ({1'b0, fz_q} >= ena_q) begin
            st_d = ST_BADFREE;
          end else begin
            st_d = ST_OK;
          end
          zone_d = fz_q;
        end
        map_addr = zone_d;
      end
      S_UPDATE: begin
        state_d = S_IDLE;
        if (st_q == ST_OK) begin
          if (func_q == FUNC_ALLOC) begin
            map_we    = 1'b1;
            map_wdata = row | (SLOTS_PER_ZONE'(1) << pe_slot);
            sz_we     = 1'b1;
            sz_addr   = {zone_q, pe_slot};
            cnt_we    = 1'b1;
            res_zone_d  = zone_q;
            res_slot_d  = pe_slot;
            res_cnt_d   = cnt_q[zone_q] + CNT_W'(1);
            res_bytes_d = bytes_q[zone_q] + BYTES_W'(size_q[SIZE_W-1:0]);
          end else if (slot_busy) begin
            map_we    = 1'b1;
            map_wdata = row & ~(SLOTS_PER_ZONE'(1) << fs_q);
            cnt_we    = 1'b1;
            res_zone_d  = zone_q;
            res_slot_d  = fs_q;
            res_cnt_d   = cnt_q[zone_q] - CNT_W'(1);
            res_bytes_d = bytes_q[zone_q] - BYTES_W'(sz_rdata);
          end else begin
            // double free
            res_st_d = ST_BADFREE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ena_q     <= ENA_W'(1);
      row_vld_q <= '0;
      done_q    <= 1'b0;
      for (int z = 0; z < MAX_ZONES; z++) begin
        cnt_q[z]   <= '0;
        bytes_q[z] <= '0;
      end
    end else begin
      state_q <= state_d;
      ena_q   <= ena_d;
      done_q  <= (state_q == S_UPDATE);
      if (map_we) begin
        row_vld_q[zone_q] <= 1'b1;
      end
      if (cnt_we) begin
        cnt_q[zone_q]   <= res_cnt_d;
        bytes_q[zone_q] <= res_bytes_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      size_q <= request_size_i;
      fz_q   <= free_zone_i;
      fs_q   <= free_slot_i;
    end
    if (state_q == S_READ) begin
      rd_vld_q <= row_vld_q[map_addr];
    end
    zone_q <= zone_d;
    st_q   <= st_d;
    if (state_q == S_UPDATE) begin
      res_st_q    <= res_st_d;
      res_zone_q  <= res_zone_d;
      res_slot_q  <= res_slot_d;
      res_cnt_q   <= res_cnt_d;
      res_bytes_q <= res_bytes_d;
    end
  end

  assign done_o              = done_q;
  assign status_o            = res_st_q;
  assign granted_zone_o      = res_zone_q;
  assign granted_slot_o      = res_slot_q;
  assign zone_used_count_o   = res_cnt_q;
  assign zone_byte_total_o   = res_bytes_q;
  assign active_zone_count_o = ena_q;

  `ZSA_ASSERT(a_done_pulse, done_o |=> !done_o, "result strobe longer than one cycle")
  `ZSA_ASSERT(a_latency, (start && !busy) |-> ##3 done_o, "result not delivered after 3 cycles")
  `ZSA_ASSERT_NEVER(a_ena_range, (ena_q == '0) || (ena_q > ENA_W'(MAX_ZONES)),
                    "active zone count out of range")
  `ZSA_ASSERT_NEVER(a_cnt_range, done_o && (zone_used_count_o > CNT_W'(SLOTS_PER_ZONE)),
                    "zone used count above zone size")

endmodule
